// ----- rtl/otp_pkg.sv -----
package otp_pkg;

    // Most expiry results one update may produce.
    localparam int unsigned MAX_EXPIRE = 8;
    localparam int unsigned CNT_W      = $clog2(MAX_EXPIRE + 1);

    // Result kinds.
    localparam logic [1:0] KIND_SET_OK  = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    // Item modes.
    localparam logic MODE_SET    = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_seconds;
        logic [31:0] timeout;
        logic [7:0]  tag;
    } otp_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] slot;
        logic [7:0] expired_tag;
        logic       last;
    } otp_out_t;

    // One stored timer (active bit lives in flops).
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] timeout;
        logic [7:0]  tag;
    } otp_entry_t;

    // Controller -> datapath.
    typedef struct packed {
        logic load;
        logic idx_inc;
        logic ram_rd;
        logic claim;
        logic refuse;
        logic expire;
        logic flush;
    } otp_cmd_t;

    // Datapath -> controller.
    typedef struct packed {
        logic mode;
        logic active_at;
        logic idx_last;
        logic due;
        logic out_free;
        logic pend_valid;
        logic count_full;
    } otp_sts_t;

endpackage

// ----- rtl/otp_ram.sv -----
module otp_ram #(
    parameter int unsigned WIDTH = 72,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/otp_ctrl.sv -----
module otp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  otp_pkg::otp_sts_t  sts,
    output otp_pkg::otp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SET   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
                if (s_valid) begin
                    state_next = ST_SET;
                end
            end
            ST_SET: begin
                // walk active bits for the lowest free slot
                if (!sts.active_at) begin
                    if (sts.out_free) begin
                        cmd.claim  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (sts.idx_last) begin
                    if (sts.out_free) begin
                        cmd.refuse = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_SCAN: begin
                priority if (sts.count_full) begin
                    state_next = ST_FLUSH;
                end else if (sts.active_at) begin
                    cmd.ram_rd = 1'b1;
                    state_next = ST_CHECK;
                end else if (sts.idx_last) begin
                    state_next = ST_FLUSH;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_CHECK: begin
                if (sts.due && sts.pend_valid && !sts.out_free) begin
                    state_next = ST_CHECK;
                end else begin
                    cmd.expire = sts.due;
                    if (sts.idx_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // mode picks the branch once the request is taken
        if (cmd.load && sts.mode == otp_pkg::MODE_UPDATE) begin
            state_next = ST_SCAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // at most one action that loads the result register per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.claim, cmd.refuse, cmd.expire, cmd.flush}) <= 1)
        else $error("conflicting result commands");

    // a new request is taken only from idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");

    // a check always follows a slot read
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ram_rd |=> state_reg == ST_CHECK)
        else $error("read not followed by check");

endmodule

// ----- rtl/otp_dpath.sv -----
module otp_dpath #(
    parameter int unsigned SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  otp_pkg::otp_in_t   s_data,
    input  logic               m_ready,
    output logic               m_valid,
    output otp_pkg::otp_out_t  m_data,
    input  otp_pkg::otp_cmd_t  cmd,
    output otp_pkg::otp_sts_t  sts
);

    localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned ENT_W = $bits(otp_pkg::otp_entry_t);

    logic [SLOTS-1:0]            active_reg, active_next;
    otp_pkg::otp_in_t            req_reg, req_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [otp_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [2:0]                  pend_slot_reg, pend_slot_next;
    logic [7:0]                  pend_tag_reg, pend_tag_next;
    logic                        m_valid_reg, m_valid_next;
    otp_pkg::otp_out_t           m_data_reg, m_data_next;

    otp_pkg::otp_entry_t         wr_entry;
    otp_pkg::otp_entry_t         rd_entry;
    logic [ENT_W-1:0]            rd_bits;
    logic [32:0]                 deadline;
    logic [IDX_W+2:0]            idx_ext;
    logic [2:0]                  slot_num;
    logic                        out_free;

    assign wr_entry = '{start: req_reg.now_seconds, timeout: req_reg.timeout, tag: req_reg.tag};

    otp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.claim),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (cmd.ram_rd),
        .raddr (idx_reg),
        .rdata (rd_bits)
    );

    assign rd_entry = otp_pkg::otp_entry_t'(rd_bits);
    // 33-bit deadline, no wrap
    assign deadline = {1'b0, rd_entry.start} + {1'b0, rd_entry.timeout};
    assign idx_ext  = (IDX_W + 3)'(idx_reg);
    assign slot_num = idx_ext[2:0];
    assign out_free = !m_valid_reg || m_ready;

    assign sts.mode       = s_data.mode;
    assign sts.active_at  = active_reg[idx_reg];
    assign sts.idx_last   = (idx_reg == IDX_W'(SLOTS - 1));
    assign sts.due        = (deadline < {1'b0, req_reg.now_seconds});
    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.count_full = (count_reg == otp_pkg::CNT_W'(otp_pkg::MAX_EXPIRE));

    always_comb begin
        active_next     = active_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_tag_next   = pend_tag_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (cmd.load) begin
            req_next        = s_data;
            idx_next        = '0;
            count_next      = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.claim) begin
            active_next[idx_reg] = 1'b1;
            m_valid_next = 1'b1;
            m_data_next  = '{kind: otp_pkg::KIND_SET_OK, slot: slot_num,
                             expired_tag: req_reg.tag, last: 1'b1};
        end
        if (cmd.refuse) begin
            m_valid_next = 1'b1;
            m_data_next  = '{kind: otp_pkg::KIND_FULL, slot: 3'd0,
                             expired_tag: req_reg.tag, last: 1'b1};
        end
        if (cmd.expire) begin
            // previous hit goes out, this one waits: only the final one is last
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = '{kind: otp_pkg::KIND_EXPIRED, slot: pend_slot_reg,
                                 expired_tag: pend_tag_reg, last: 1'b0};
            end
            active_next[idx_reg] = 1'b0;
            pend_valid_next      = 1'b1;
            pend_slot_next       = slot_num;
            pend_tag_next        = rd_entry.tag;
            count_next           = count_reg + otp_pkg::CNT_W'(1);
        end
        if (cmd.flush) begin
            m_valid_next    = 1'b1;
            m_data_next     = '{kind: otp_pkg::KIND_EXPIRED, slot: pend_slot_reg,
                                expired_tag: pend_tag_reg, last: 1'b1};
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            active_reg     <= active_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.claim |-> !active_reg[idx_reg])
        else $error("claim of a busy slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.expire |-> active_reg[idx_reg])
        else $error("expiry of an idle slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.claim || cmd.refuse || cmd.flush || (cmd.expire && pend_valid_reg))
        |-> out_free)
        else $error("result register overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= otp_pkg::CNT_W'(otp_pkg::MAX_EXPIRE) || cmd.load)
        else $error("expiry count overrun");

endmodule

// ----- rtl/one_shot_timer_pool.sv -----
// A set request walks the active bits for the lowest free slot, one active bit per cycle;
// a busy result channel stalls the answer. An update steps over each idle slot, reads each
// active slot from the RAM, then compares its deadline, and ends in a closing state that emits
// the held-back final expiry, if any; a busy result channel can stall the compare and the close.
// It stops early after 8 expiries. One request is handled at a time. Reset (aresetn low, sync)
// clears active bits, expiry count, held-back expiry flag, output valid and state, not the RAM.
module one_shot_timer_pool #(
    parameter int unsigned SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  otp_pkg::otp_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output otp_pkg::otp_out_t  m_data
);

    // Controller sequences one request: a set walks the active bits for the
    // lowest free slot; an update walks the slots, reads start/timeout/tag of each
    // active slot from the slot RAM and compares the 33-bit deadline with the time.
    otp_pkg::otp_cmd_t cmd;
    otp_pkg::otp_sts_t sts;

    otp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath holds the request, slot index, active bits, slot RAM, one
    // held-back expiry (so the final one can be marked last) and the
    // output register, which decouples the result channel from the walk.
    otp_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = 8;
    // Wait covering the longest quiet walk of the block, with every slot read and compared.
    localparam int unsigned WALK_CYCLES = 2 * SLOTS + 4;
    // Random base times are drawn up to this, so a max-time sweep can always free the timers.
    localparam logic [31:0] BASE_TIME_MAX = 32'hE000_0000;
    localparam logic [31:0] LONG_TIMEOUT_MAX = 32'h0FFF_FFFF;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    otp_pkg::otp_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    otp_pkg::otp_out_t m_data;

    // Idle odds in percent, changed per test.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count   = 0;

    // Shadow copy of the timer pool, updated on every accepted request.
    logic        timer_active [SLOTS];
    logic [31:0] timer_start  [SLOTS];
    logic [31:0] timer_timeout[SLOTS];
    logic [7:0]  timer_tag    [SLOTS];

    // Results still owed by the block, oldest first.
    otp_pkg::otp_out_t pending_results[$];

    always #2 aclk = ~aclk;

    one_shot_timer_pool #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // ------------------------------------------------------------------
    // Timer pool prediction
    // ------------------------------------------------------------------

    task automatic clear_pool();
        for (int i = 0; i < SLOTS; i++) begin
            timer_active[i]  = 1'b0;
            timer_start[i]   = '0;
            timer_timeout[i] = '0;
            timer_tag[i]     = '0;
        end
    endtask

    // Applies one accepted request to the shadow pool and queues its results.
    task automatic predict_timer_results(input otp_pkg::otp_in_t req);
        otp_pkg::otp_out_t res;
        otp_pkg::otp_out_t expiries[$];
        logic [32:0]       deadline;
        bit                claimed;
        if (req.mode == otp_pkg::MODE_SET) begin
            claimed = 1'b0;
            res = '{kind: otp_pkg::KIND_FULL, slot: 3'd0, expired_tag: req.tag,
                    last: 1'b1};
            for (int i = 0; i < SLOTS; i++) begin
                if (!claimed && !timer_active[i]) begin
                    claimed          = 1'b1;
                    timer_active[i]  = 1'b1;
                    timer_start[i]   = req.now_seconds;
                    timer_timeout[i] = req.timeout;
                    timer_tag[i]     = req.tag;
                    res = '{kind: otp_pkg::KIND_SET_OK, slot: 3'(i), expired_tag: req.tag,
                            last: 1'b1};
                end
            end
            pending_results.push_back(res);
        end else begin
            // Deadline is carried one bit wider so it never wraps.
            for (int i = 0; i < SLOTS && expiries.size() < otp_pkg::MAX_EXPIRE; i++) begin
                deadline = {1'b0, timer_start[i]} + {1'b0, timer_timeout[i]};
                if (timer_active[i] && deadline < {1'b0, req.now_seconds}) begin
                    res = '{kind: otp_pkg::KIND_EXPIRED, slot: 3'(i),
                            expired_tag: timer_tag[i], last: 1'b0};
                    expiries.push_back(res);
                    // start time is kept on free, the rest is cleared
                    timer_active[i]  = 1'b0;
                    timer_timeout[i] = '0;
                    timer_tag[i]     = '0;
                end
            end
            if (expiries.size() > 0)
                expiries[expiries.size() - 1].last = 1'b1;
            foreach (expiries[k])
                pending_results.push_back(expiries[k]);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------

    function automatic otp_pkg::otp_in_t make_request(input logic mode,
                                                      input logic [31:0] now,
                                                      input logic [31:0] tmo,
                                                      input logic [7:0] tag);
        otp_pkg::otp_in_t req;
        req.mode        = mode;
        req.now_seconds = now;
        req.timeout     = tmo;
        req.tag         = tag;
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input otp_pkg::otp_in_t req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        predict_timer_results(req);
        @(negedge aclk);
    endtask

    // Holds the sender off until every owed result is out, then lets
    // a possible result-free walk finish.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (WALK_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure and checking
    // ------------------------------------------------------------------

    always @(negedge aclk)
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin : check_results
        otp_pkg::otp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d slot=%0d tag=%02h last=%0b",
                                          m_data.kind, m_data.slot, m_data.expired_tag,
                                          m_data.last));
            end else begin
                want = pending_results.pop_front();
                if (m_data.kind !== want.kind || m_data.slot !== want.slot ||
                    m_data.expired_tag !== want.expired_tag || m_data.last !== want.last)
                    report_mismatch($sformatf(
                        "got kind=%0d slot=%0d tag=%02h last=%0b, want %0d/%0d/%02h/%0b",
                        m_data.kind, m_data.slot, m_data.expired_tag, m_data.last,
                        want.kind, want.slot, want.expired_tag, want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, zero timeout, pool full, nothing due, multi-expiry,
    // and an update that frees all eight slots at once.
    task automatic test_directed();
        send_request(make_request(otp_pkg::MODE_SET, 32'd0, 32'd0, 8'h00));
        send_request(make_request(otp_pkg::MODE_SET, 32'd0, 32'h7FFF_FFFF, 8'hFF));
        send_request(make_request(otp_pkg::MODE_SET, 32'd0, 32'h8000_0000, 8'hA5));
        send_request(make_request(otp_pkg::MODE_SET, 32'h5555_5555, 32'h0000_AAAA, 8'h5A));
        for (int i = 1; i <= 4; i++)
            send_request(make_request(otp_pkg::MODE_SET, 32'd10, 32'd5, 8'(i)));
        // pool is full now: refused, state untouched
        send_request(make_request(otp_pkg::MODE_SET, 32'd10, 32'd1, 8'h3C));
        // sender holds off until the whole backlog is out
        wait_results_drained();
        // nothing due at time zero
        send_request(make_request(otp_pkg::MODE_UPDATE, 32'd0, 32'hFFFF_FFFF, 8'hFF));
        // zero timeout expires once time passes the start
        send_request(make_request(otp_pkg::MODE_UPDATE, 32'd1, 32'd0, 8'h00));
        // four timers due together, last flag on the final one
        send_request(make_request(otp_pkg::MODE_UPDATE, 32'd16, 32'd0, 8'h00));
        // deadline equal to now is not due
        send_request(make_request(otp_pkg::MODE_UPDATE, 32'h8000_0000, 32'd0, 8'h00));
        send_request(make_request(otp_pkg::MODE_UPDATE, 32'h8000_0001, 32'd0, 8'h00));
        send_request(make_request(otp_pkg::MODE_UPDATE, TIME_MAX, 32'd0, 8'h00));
        for (int i = 0; i < SLOTS; i++)
            send_request(make_request(otp_pkg::MODE_SET, 32'd20, 32'(i), 8'(8'hC0 + i)));
        send_request(make_request(otp_pkg::MODE_UPDATE, TIME_MAX, 32'd0, 8'h00));
        wait_results_drained();
    endtask

    // Bursts of sets and advancing updates around a random base time, with
    // stale-time updates as noise; each burst closes with a max-time sweep.
    task automatic test_random(input int unsigned item_count, input int unsigned send_pct,
                               input int unsigned recv_pct);
        logic [31:0] base_time;
        logic [31:0] tmo;
        int unsigned pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        base_time = $urandom_range(0, BASE_TIME_MAX);
        for (int n = 1; n <= item_count; n++) begin
            pick = $urandom_range(0, 99);
            if (n % 25 == 0 || n == item_count) begin
                send_request(make_request(otp_pkg::MODE_UPDATE, TIME_MAX, $urandom,
                                          8'($urandom)));
                base_time = $urandom_range(0, BASE_TIME_MAX);
            end else if (pick < 50) begin
                if ($urandom_range(0, 99) < 85)
                    tmo = $urandom_range(0, 40);
                else
                    tmo = $urandom_range(0, LONG_TIMEOUT_MAX);
                send_request(make_request(otp_pkg::MODE_SET, base_time, tmo, 8'($urandom)));
            end else if (pick < 90) begin
                base_time += $urandom_range(0, 25);
                send_request(make_request(otp_pkg::MODE_UPDATE, base_time, $urandom,
                                          8'($urandom)));
            end else begin
                send_request(make_request(otp_pkg::MODE_UPDATE, $urandom_range(0, base_time),
                                          $urandom, 8'($urandom)));
            end
        end
        wait_results_drained();
    endtask

    // Deadlines past 32 bits must not wrap. These timers never expire,
    // so this runs last.
    task automatic test_no_wrap();
        send_request(make_request(otp_pkg::MODE_SET, TIME_MAX, TIME_MAX, 8'h11));
        send_request(make_request(otp_pkg::MODE_SET, 32'h8000_0000, 32'h8000_0000, 8'h22));
        send_request(make_request(otp_pkg::MODE_UPDATE, 32'd1, 32'd0, 8'h00));
        send_request(make_request(otp_pkg::MODE_UPDATE, TIME_MAX, 32'd0, 8'h00));
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_pool();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 38;
        recv_idle_pct = 79;
        test_directed();
        test_random(125, 38, 79);
        test_random(125, 79, 38);
        test_random(125, 0, 0);
        test_no_wrap();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/otp_pkg.sv
rtl/otp_ram.sv
rtl/otp_ctrl.sv
rtl/otp_dpath.sv
rtl/one_shot_timer_pool.sv
verif/testbench.sv
